[rtl/core/imut_pkg.sv]
// ============================================================================
// imut_pkg: shared types and constants for the IMU tilt integrator
// Field widths, register indexes, sequencing step codes and the command
// structure that passes from the controller to the datapath.
// ============================================================================
package imut_pkg;

    // Fixed field widths
    localparam int RAW_W       = 16;
    localparam int CORR_W      = RAW_W + 1;
    localparam int PROD_W      = 2 * CORR_W;
    localparam int SQ_SUM_W    = 34;
    localparam int ROOT_W      = SQ_SUM_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int OUT_ANGLE_W = 40;
    localparam int MAG_W       = 19;
    localparam int CFG_IDX_W   = 3;

    // Default accumulator width
    localparam int ANGLE_BITS_DEF = 40;

    // Magnitude scale: counts to 1/256 m/s^2 as a multiply and a shift
    localparam int SCALE_W     = 11;
    localparam int SCALE_SHIFT = 10;
    localparam logic [SCALE_W-1:0] SCALE_MUL = 11'd1256;
    localparam int SCALED_W    = ROOT_W + SCALE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z  = 3'd4;

    // Sequencer counts
    localparam int MUL_STEPS  = 5;
    localparam int MAC_STEPS  = MUL_STEPS + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // Multiply / accumulate step codes
    typedef logic [2:0] step_t;
    localparam step_t STEP_GX = 3'd0;
    localparam step_t STEP_GZ = 3'd1;
    localparam step_t STEP_DX = 3'd2;
    localparam step_t STEP_DY = 3'd3;
    localparam step_t STEP_DZ = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  load;
        logic  mul_en;
        step_t mul_sel;
        logic  acc_en;
        step_t acc_sel;
        logic  sqrt_load;
        logic  sqrt_step;
        logic  out_load;
    } cmd_t;

endpackage

[rtl/core/imu_tilt_integrator.sv]
// ============================================================================
// imu_tilt_integrator: gyro tilt integration and accelerometer magnitude
// Removes configured offsets from a raw IMU sample, integrates the X and Z
// gyro rates into saturating angle sums and reports the acceleration
// magnitude.
//
//   channel   direction   handshake                   payload
//   sample    in          sample_valid / sample_stall  accel_x..z, gyro_x/z,
//                                                      elapsed_ms
//   result    out         result_valid / result_stall  tilt_change_x/z,
//                                                      accel_magnitude
//   config    in          cfg_we                       cfg_index, cfg_data
//
// A sample passes from its transfer to a valid result through six
// multiply-accumulate steps on one shared multiplier, one load and 17
// square root iterations, then the output load; the next sample is taken
// in the cycle after that load. A result held by result_stall stays in the
// output register while the next sample is processed; the output load waits
// for it to leave. Reset clears the offsets, angle sums and control state.
// ============================================================================
module imu_tilt_integrator #(
    parameter int ANGLE_BITS = imut_pkg::ANGLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [imut_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [imut_pkg::RAW_W-1:0]              cfg_data,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_x,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_y,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_z,
    input  logic signed [imut_pkg::RAW_W-1:0]       gyro_x,
    input  logic signed [imut_pkg::RAW_W-1:0]       gyro_z,
    input  logic [imut_pkg::RAW_W-1:0]              elapsed_ms,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [imut_pkg::OUT_ANGLE_W-1:0] tilt_change_x,
    output logic signed [imut_pkg::OUT_ANGLE_W-1:0] tilt_change_z,
    output logic [imut_pkg::MAG_W-1:0]              accel_magnitude
);
    import imut_pkg::*;

    cmd_t cmd;

    // Sequencing controller.
    imut_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // Arithmetic datapath.
    imut_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .gyro_x          (gyro_x),
        .gyro_z          (gyro_z),
        .elapsed_ms      (elapsed_ms),
        .cmd             (cmd),
        .tilt_change_x   (tilt_change_x),
        .tilt_change_z   (tilt_change_z),
        .accel_magnitude (accel_magnitude)
    );

    // A sample transfer always starts a busy period.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample accepted but block not busy");

    // A new result appears only at the end of a busy period.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result raised without work in progress");

    // Datapath phases never overlap.
    a_phases_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en || cmd.acc_en, cmd.sqrt_load,
                  cmd.sqrt_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // Loading the output never drops a result that is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result_valid && result_stall))
        else $error("output loaded over a held result");

endmodule

[rtl/core/imut_ctrl.sv]
// ============================================================================
// imut_ctrl: sequencing controller for the IMU tilt integrator
// Walks each sample through the multiply-accumulate steps, the square root
// iterations and the output load, and owns the result valid flag.
// ============================================================================
module imut_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_stall,
    output logic          result_valid,
    input  logic          result_stall,
    output imut_pkg::cmd_t cmd
);
    import imut_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              mac_last, sqrt_last, out_free;

    assign mac_last  = (cnt_reg == CNT_W'(MAC_STEPS - 1));
    assign sqrt_last = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
    assign out_free  = !out_valid_reg || !result_stall;

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_last)
                begin
                    state_next = ST_SQ_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQ_LOAD:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands for the current state.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = sample_valid;
            end
            ST_MAC:
            begin
                cmd.mul_en  = (cnt_reg < CNT_W'(MUL_STEPS));
                cmd.mul_sel = step_t'(cnt_reg);
                cmd.acc_en  = (cnt_reg != '0);
                cmd.acc_sel = step_t'(cnt_reg - 1'b1);
            end
            ST_SQ_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // The result stays valid until its transfer completes.
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

[rtl/core/imut_dp.sv]
// ============================================================================
// imut_dp: datapath for the IMU tilt integrator
// Offset registers, one shared 17x17 multiplier with a saturating
// accumulator, a bit-pair square root unit and the output registers.
// ============================================================================
module imut_dp #(
    parameter int ANGLE_BITS = imut_pkg::ANGLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [imut_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [imut_pkg::RAW_W-1:0]              cfg_data,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_x,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_y,
    input  logic signed [imut_pkg::RAW_W-1:0]       accel_z,
    input  logic signed [imut_pkg::RAW_W-1:0]       gyro_x,
    input  logic signed [imut_pkg::RAW_W-1:0]       gyro_z,
    input  logic [imut_pkg::RAW_W-1:0]              elapsed_ms,
    input  imut_pkg::cmd_t                          cmd,
    output logic signed [imut_pkg::OUT_ANGLE_W-1:0] tilt_change_x,
    output logic signed [imut_pkg::OUT_ANGLE_W-1:0] tilt_change_z,
    output logic [imut_pkg::MAG_W-1:0]              accel_magnitude
);
    import imut_pkg::*;

    localparam int SUM_W = ((ANGLE_BITS > PROD_W) ? ANGLE_BITS : PROD_W) + 1;

    // Offset registers
    logic signed [RAW_W-1:0] off_ax_reg, off_ay_reg, off_az_reg, off_gx_reg, off_gz_reg;

    // Corrected sample
    logic signed [CORR_W-1:0] dx_reg, dy_reg, dz_reg, gx_reg, gz_reg;
    logic [RAW_W-1:0]         ms_reg;

    // Multiply-accumulate
    logic signed [CORR_W-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ANGLE_BITS-1:0] angle_x_reg, angle_z_reg, acc_in;
    logic signed [SUM_W-1:0]      sum, sum_hi, sum_lo;
    logic signed [ANGLE_BITS-1:0] sat_sum;
    logic [SQ_SUM_W-1:0]          sq_sum_reg;

    // Square root
    logic [SQ_SUM_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W+1:0]    rem_trial, root_trial;
    logic                trial_ok;

    // Output
    logic [SCALED_W-1:0]           scaled;
    logic signed [OUT_ANGLE_W-1:0] tilt_x_reg, tilt_z_reg;
    logic [MAG_W-1:0]              mag_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_ax_reg <= '0;
            off_ay_reg <= '0;
            off_az_reg <= '0;
            off_gx_reg <= '0;
            off_gz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACCEL_OFFSET_X: off_ax_reg <= signed'(cfg_data);
                REG_ACCEL_OFFSET_Y: off_ay_reg <= signed'(cfg_data);
                REG_ACCEL_OFFSET_Z: off_az_reg <= signed'(cfg_data);
                REG_GYRO_OFFSET_X:  off_gx_reg <= signed'(cfg_data);
                REG_GYRO_OFFSET_Z:  off_gz_reg <= signed'(cfg_data);
                default:            ;
            endcase
        end
    end

    // Capture the sample with the offsets removed at 17 bits.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg <= CORR_W'(accel_x) - CORR_W'(off_ax_reg);
            dy_reg <= CORR_W'(accel_y) - CORR_W'(off_ay_reg);
            dz_reg <= CORR_W'(accel_z) - CORR_W'(off_az_reg);
            gx_reg <= CORR_W'(gyro_x) - CORR_W'(off_gx_reg);
            gz_reg <= CORR_W'(gyro_z) - CORR_W'(off_gz_reg);
            ms_reg <= elapsed_ms;
        end
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            STEP_GX:
            begin
                mul_a = gx_reg;
                mul_b = signed'({1'b0, ms_reg});
            end
            STEP_GZ:
            begin
                mul_a = gz_reg;
                mul_b = signed'({1'b0, ms_reg});
            end
            STEP_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            STEP_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            STEP_DZ:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // Saturating add of the last product into the selected angle.
    assign acc_in  = (cmd.acc_sel == STEP_GX) ? angle_x_reg : angle_z_reg;
    assign sum     = SUM_W'(acc_in) + SUM_W'(prod_reg);
    assign sum_hi  = SUM_W'(signed'({1'b0, {(ANGLE_BITS - 1){1'b1}}}));
    assign sum_lo  = ~sum_hi;

    always_comb
    begin
        if (sum > sum_hi)
        begin
            sat_sum = sum_hi[ANGLE_BITS-1:0];
        end
        else if (sum < sum_lo)
        begin
            sat_sum = sum_lo[ANGLE_BITS-1:0];
        end
        else
        begin
            sat_sum = sum[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_z_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (cmd.acc_sel == STEP_GX)
            begin
                angle_x_reg <= sat_sum;
            end
            else if (cmd.acc_sel == STEP_GZ)
            begin
                angle_z_reg <= sat_sum;
            end
        end
    end

    // Sum of squares; each square is non-negative and below 2^32.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_sum_reg <= '0;
        end
        else if (cmd.acc_en && (cmd.acc_sel != STEP_GX) && (cmd.acc_sel != STEP_GZ))
        begin
            sq_sum_reg <= sq_sum_reg + SQ_SUM_W'(prod_reg[PROD_W-3:0]);
        end
    end

    // Restoring square root, one result bit per step.
    assign rem_trial  = {rem_reg, rad_reg[SQ_SUM_W-1 -: 2]};
    assign root_trial = {1'b0, root_reg, 2'b01};
    assign trial_ok   = (rem_trial >= root_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            rad_reg  <= sq_sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[SQ_SUM_W-3:0], 2'b00};
            rem_reg  <= trial_ok ? REM_W'(rem_trial - root_trial) : REM_W'(rem_trial);
            root_reg <= {root_reg[ROOT_W-2:0], trial_ok};
        end
    end

    // Scale the root and load the result registers.
    assign scaled = SCALED_W'(root_reg) * SCALED_W'(SCALE_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            tilt_x_reg <= OUT_ANGLE_W'(angle_x_reg);
            tilt_z_reg <= OUT_ANGLE_W'(angle_z_reg);
            mag_reg    <= MAG_W'(scaled[SCALED_W-1:SCALE_SHIFT]);
        end
    end

    assign tilt_change_x   = tilt_x_reg;
    assign tilt_change_z   = tilt_z_reg;
    assign accel_magnitude = mag_reg;

endmodule

[bench/tb_imu_tilt_integrator.sv]
// ============================================================================
// tb_imu_tilt_integrator: self-checking bench for the IMU tilt integrator
// A queue of IMU samples feeds a clocked driver. For every sample transfer
// the bench predicts the saturating X and Z angle sums and the acceleration
// magnitude. A clocked monitor checks each result transfer against the
// oldest prediction. Both sides insert random gaps and stalls. Offset
// settings change only while the block is idle. The settings include both
// extremes and runs that push the angle sums into both saturation rails.
// ============================================================================
module tb_imu_tilt_integrator;

    import imut_pkg::*;

    localparam int ANGLE_W         = ANGLE_BITS_DEF;
    localparam int NUM_OFFSET_REGS = 5;
    localparam int MAG_SCALE       = 1256;
    localparam int MAG_SHIFT       = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int QUIET_FIRST     = 330;
    localparam int QUIET_LAST      = 470;

    typedef struct {
        logic signed [RAW_W-1:0] ax;
        logic signed [RAW_W-1:0] ay;
        logic signed [RAW_W-1:0] az;
        logic signed [RAW_W-1:0] gx;
        logic signed [RAW_W-1:0] gz;
        logic [RAW_W-1:0]        ms;
    } imu_sample_t;

    typedef struct {
        logic signed [OUT_ANGLE_W-1:0] tilt_x;
        logic signed [OUT_ANGLE_W-1:0] tilt_z;
        logic [MAG_W-1:0]              mag;
    } tilt_reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAW_W-1:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [RAW_W-1:0] accel_x = '0;
    logic signed [RAW_W-1:0] accel_y = '0;
    logic signed [RAW_W-1:0] accel_z = '0;
    logic signed [RAW_W-1:0] gyro_x = '0;
    logic signed [RAW_W-1:0] gyro_z = '0;
    logic [RAW_W-1:0] elapsed_ms = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [OUT_ANGLE_W-1:0] tilt_change_x;
    logic signed [OUT_ANGLE_W-1:0] tilt_change_z;
    logic [MAG_W-1:0] accel_magnitude;

    // Bench copy of the offset registers and the angle accumulators
    logic signed [RAW_W-1:0] offset_shadow [NUM_OFFSET_REGS];
    longint angle_acc_x = 0;
    longint angle_acc_z = 0;

    imu_sample_t   sample_queue [$];
    tilt_reading_t expected_readings [$];
    imu_sample_t   current_sample;
    int samples_sent = 0;
    int readings_checked = 0;
    int mismatch_count = 0;
    int setting_count = 1;
    int long_stall_left = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;

    imu_tilt_integrator #(
        .ANGLE_BITS(ANGLE_W)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .gyro_x         (gyro_x),
        .gyro_z         (gyro_z),
        .elapsed_ms     (elapsed_ms),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .tilt_change_x  (tilt_change_x),
        .tilt_change_z  (tilt_change_z),
        .accel_magnitude(accel_magnitude)
    );

    always #2 clk = ~clk;

    // Saturating add at the accumulator width.
    function automatic longint sat_accumulate(longint acc, longint delta);
        longint top;
        longint bottom;
        top = (longint'(1) << (ANGLE_W - 1)) - 1;
        bottom = -top - 1;
        if (delta > 0 && acc > top - delta)
            return top;
        if (delta < 0 && acc < bottom - delta)
            return bottom;
        return acc + delta;
    endfunction

    // Bitwise integer square root, two bits of the radicand per pass.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'h1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n -= root + probe;
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Advances the angle sums by one sample and forms the expected result.
    function automatic tilt_reading_t predict_reading(imu_sample_t s);
        longint dx;
        longint dy;
        longint dz;
        longint gx;
        longint gz;
        longint ms;
        longint unsigned energy;
        longint unsigned scaled;
        tilt_reading_t r;
        dx = longint'(s.ax) - longint'(offset_shadow[REG_ACCEL_OFFSET_X]);
        dy = longint'(s.ay) - longint'(offset_shadow[REG_ACCEL_OFFSET_Y]);
        dz = longint'(s.az) - longint'(offset_shadow[REG_ACCEL_OFFSET_Z]);
        gx = longint'(s.gx) - longint'(offset_shadow[REG_GYRO_OFFSET_X]);
        gz = longint'(s.gz) - longint'(offset_shadow[REG_GYRO_OFFSET_Z]);
        ms = longint'(s.ms);
        angle_acc_x = sat_accumulate(angle_acc_x, gx * ms);
        angle_acc_z = sat_accumulate(angle_acc_z, gz * ms);
        energy = dx * dx + dy * dy + dz * dz;
        scaled = (int_sqrt(energy) * MAG_SCALE) >> MAG_SHIFT;
        r.tilt_x = angle_acc_x[OUT_ANGLE_W-1:0];
        r.tilt_z = angle_acc_z[OUT_ANGLE_W-1:0];
        r.mag = scaled[MAG_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Stimulus helpers
    function automatic void push_sample(logic [RAW_W-1:0] ax, logic [RAW_W-1:0] ay,
                                        logic [RAW_W-1:0] az, logic [RAW_W-1:0] gx,
                                        logic [RAW_W-1:0] gz, logic [RAW_W-1:0] ms);
        imu_sample_t s;
        s.ax = ax;
        s.ay = ay;
        s.az = az;
        s.gx = gx;
        s.gz = gz;
        s.ms = ms;
        sample_queue.push_back(s);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return RAW_W'(int'($urandom_range(6000)) - 3000);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_interval();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return RAW_W'($urandom_range(20, 1));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic void push_random_sample();
        push_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                    pick_interval());
    endfunction

    // Near-full-scale rates of opposite sign on the two gyro axes.
    function automatic void push_sweep_sample(bit x_up);
        logic [RAW_W-1:0] rate_hi;
        logic [RAW_W-1:0] rate_lo;
        rate_hi = RAW_W'(32767 - int'($urandom_range(15)));
        rate_lo = RAW_W'(-32768 + int'($urandom_range(15)));
        push_sample(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                    x_up ? rate_hi : rate_lo, x_up ? rate_lo : rate_hi,
                    RAW_W'(65535 - int'($urandom_range(400))));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx < NUM_OFFSET_REGS)
            offset_shadow[idx] = value;
    endtask

    // Writes all five offsets, then one write to an unused index.
    task automatic load_offsets(input logic [RAW_W-1:0] ax, input logic [RAW_W-1:0] ay,
                                input logic [RAW_W-1:0] az, input logic [RAW_W-1:0] gx,
                                input logic [RAW_W-1:0] gz);
        cfg_write(REG_ACCEL_OFFSET_X, ax);
        cfg_write(REG_ACCEL_OFFSET_Y, ay);
        cfg_write(REG_ACCEL_OFFSET_Z, az);
        cfg_write(REG_GYRO_OFFSET_X, gx);
        cfg_write(REG_GYRO_OFFSET_Z, gz);
        cfg_write(CFG_IDX_W'(NUM_OFFSET_REGS + $urandom_range(2)), RAW_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Waits until every queued sample is transferred and every result is back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || sample_valid || expected_readings.size() != 0);
    endtask

    function automatic bit sender_gap();
        return !quiet && ($urandom_range(99) < 9);
    endfunction

    // The idle-free stretch is keyed to the transfer count.
    always @(negedge clk)
    begin
        quiet <= samples_sent >= QUIET_FIRST && samples_sent < QUIET_LAST;
    end

    // Sample driver: predicts on each transfer, then loads the next sample.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_readings.push_back(predict_reading(current_sample));
                samples_sent++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (sample_queue.size() > 0 && !sender_gap())
                begin
                    current_sample = sample_queue.pop_front();
                    accel_x <= current_sample.ax;
                    accel_y <= current_sample.ay;
                    accel_z <= current_sample.az;
                    gyro_x <= current_sample.gx;
                    gyro_z <= current_sample.gz;
                    elapsed_ms <= current_sample.ms;
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_reading();
        tilt_reading_t want;
        if (expected_readings.size() == 0)
        begin
            flag_mismatch("result transfer with no sample outstanding");
        end
        else
        begin
            want = expected_readings.pop_front();
            readings_checked++;
            if (tilt_change_x !== want.tilt_x)
                flag_mismatch($sformatf("tilt_change_x got %0d want %0d",
                                        tilt_change_x, want.tilt_x));
            if (tilt_change_z !== want.tilt_z)
                flag_mismatch($sformatf("tilt_change_z got %0d want %0d",
                                        tilt_change_z, want.tilt_z));
            if (accel_magnitude !== want.mag)
                flag_mismatch($sformatf("accel_magnitude got %0d want %0d",
                                        accel_magnitude, want.mag));
        end
    endtask

    // Result monitor: checks each transfer and drives random stalls,
    // with an occasional long stall that holds a result across the next sample.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_reading();
            if (long_stall_left > 0)
            begin
                long_stall_left--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(999) == 0)
            begin
                long_stall_left = $urandom_range(40, 10);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= !quiet && ($urandom_range(99) < 9);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_readings.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (offset_shadow[i])
            offset_shadow[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples with offsets at their reset value.
        push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        push_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
        push_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        push_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h8000);
        push_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
        push_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA);
        push_sample(16'h0000, 16'h0000, 16'h0800, 16'h0000, 16'h0000, 16'h000A);
        wait_idle();

        // Extreme offsets: corrected axes reach 17 bits, then X climbs to the
        // top rail and Z falls to the bottom rail and both stay there.
        load_offsets(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        push_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        repeat (150) push_sweep_sample(1'b1);
        wait_idle();

        // Zero offsets: both sums move back off the rails.
        load_offsets(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        repeat (20) push_sweep_sample(1'b0);
        wait_idle();

        // Random offsets and random samples, with a full drain in the middle.
        load_offsets(pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw());
        repeat (150) push_random_sample();
        wait_idle();
        repeat (150) push_random_sample();
        wait_idle();

        // Opposite extremes: X falls to the bottom rail and Z climbs to the top.
        load_offsets(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        repeat (280) push_sweep_sample(1'b0);
        wait_idle();
        load_offsets(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        repeat (20) push_sweep_sample(1'b1);
        wait_idle();

        // Final random stretch under fresh random offsets.
        load_offsets(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                     RAW_W'($urandom), RAW_W'($urandom));
        repeat (80) push_random_sample();
        wait_idle();
        repeat (30) @(posedge clk);

        $display("Checked %0d results from %0d samples over %0d offset settings,",
                 readings_checked, samples_sent, setting_count);
        $display("including both saturation rails and zero intervals; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
